// ----- rtl/sfi_pkg.sv -----
// Shared types, constants and fixed-point helpers of the steering force integrator.
// Used by sfi_front, sfi_fifo, sfi_back and the top level; depends on nothing else.
package sfi_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 288;
  localparam int unsigned IN_TUSER_W  = 4;
  localparam int unsigned OUT_TDATA_W = 136;

  typedef logic signed [31:0] q16_t;

  localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q_MIN = 32'sh8000_0000;

  // Raw opcode values as they arrive on the input stream.
  localparam logic [3:0] OPC_PUSH    = 4'd0;
  localparam logic [3:0] OPC_SEEK    = 4'd1;
  localparam logic [3:0] OPC_FLEE    = 4'd2;
  localparam logic [3:0] OPC_ARRIVE  = 4'd3;
  localparam logic [3:0] OPC_PURSUE  = 4'd4;
  localparam logic [3:0] OPC_EVADE   = 4'd5;
  localparam logic [3:0] OPC_HALT    = 4'd6;
  localparam logic [3:0] OPC_INTEG   = 4'd7;
  localparam logic [3:0] OPC_CLEAR   = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_EPS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARR_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EVADE_DIST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRED_DAMP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_SPEED  = 3'd6;

  typedef enum logic [3:0] {
    OP_PUSH, OP_SEEK, OP_FLEE, OP_ARRIVE, OP_PURSUE, OP_EVADE,
    OP_HALT, OP_INTEG, OP_CLEAR, OP_NONE
  } op_e;

  typedef struct packed {
    op_e  op;
    q16_t own_x;
    q16_t own_y;
    q16_t goal_x;
    q16_t goal_y;
    q16_t push_x;
    q16_t push_y;
    q16_t gain;
    q16_t prey_vx;
    q16_t prey_vy;
  } item_t;

  typedef struct packed {
    logic [30:0] max_force;
    logic [30:0] max_speed;
    logic [16:0] rest_eps;
    logic [30:0] arr_radius;
    logic [30:0] evade_dist;
    logic [30:0] pred_damp;
    logic [30:0] top_speed;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MAG_X, S_MAG_Y, S_MAG_S, S_MAG_W, S_DIV_W,
    S_UNIT_X, S_UNIT_Y, S_UNIT_E, S_SLOW, S_SL_M, S_SL_W,
    S_FRC_X, S_FRC_Y, S_FRC_E, S_PRED, S_LEAD, S_FACT, S_FACT_W,
    S_PX, S_PY, S_PE, S_CL_A, S_CL_B, S_CL_C, S_CL_D, S_CL_E,
    S_INT_V, S_DONE
  } state_e;

  function automatic q16_t sat33(logic [32:0] v);
    q16_t r;
    if (v[32] != v[31]) begin
      r = v[32] ? Q_MIN : Q_MAX;
    end else begin
      r = q16_t'(v[31:0]);
    end
    return r;
  endfunction

  function automatic q16_t sat_add(q16_t a, q16_t b);
    return sat33({a[31], a} + {b[31], b});
  endfunction

  function automatic q16_t sat_sub(q16_t a, q16_t b);
    return sat33({a[31], a} - {b[31], b});
  endfunction

  // Floor of a Q16.16 product, saturated to 32 bits.
  function automatic q16_t qmul_sat(logic signed [63:0] p);
    logic signed [63:0] sh;
    q16_t r;
    sh = p >>> 16;
    if (sh[63:31] != {33{sh[63]}}) begin
      r = sh[63] ? Q_MIN : Q_MAX;
    end else begin
      r = q16_t'(sh[31:0]);
    end
    return r;
  endfunction

  function automatic logic [31:0] abs_mag(q16_t v);
    logic [31:0] u;
    u = v;
    return v[31] ? (32'd0 - u) : u;
  endfunction

  function automatic q16_t apply_sign(logic [31:0] mag, logic neg);
    return neg ? q16_t'(32'd0 - mag) : q16_t'(mag);
  endfunction

endpackage

// ----- rtl/sfi_front.sv -----
// Input side of the steering force integrator: takes stream items, decodes the opcode.
// Depends on sfi_pkg; feeds sfi_fifo.
module sfi_front (
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sfi_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic [sfi_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  input  logic                               full_i,
  output logic                               push_o,
  output sfi_pkg::item_t                     item_o
);

  sfi_pkg::op_e op;

  always_comb begin
    unique case (s_axis_tuser)
      sfi_pkg::OPC_PUSH:   op = sfi_pkg::OP_PUSH;
      sfi_pkg::OPC_SEEK:   op = sfi_pkg::OP_SEEK;
      sfi_pkg::OPC_FLEE:   op = sfi_pkg::OP_FLEE;
      sfi_pkg::OPC_ARRIVE: op = sfi_pkg::OP_ARRIVE;
      sfi_pkg::OPC_PURSUE: op = sfi_pkg::OP_PURSUE;
      sfi_pkg::OPC_EVADE:  op = sfi_pkg::OP_EVADE;
      sfi_pkg::OPC_HALT:   op = sfi_pkg::OP_HALT;
      sfi_pkg::OPC_INTEG:  op = sfi_pkg::OP_INTEG;
      sfi_pkg::OPC_CLEAR:  op = sfi_pkg::OP_CLEAR;
      default:             op = sfi_pkg::OP_NONE;
    endcase
  end

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  always_comb begin
    item_o.op      = op;
    item_o.own_x   = s_axis_tdata[31:0];
    item_o.own_y   = s_axis_tdata[63:32];
    item_o.goal_x  = s_axis_tdata[95:64];
    item_o.goal_y  = s_axis_tdata[127:96];
    item_o.push_x  = s_axis_tdata[159:128];
    item_o.push_y  = s_axis_tdata[191:160];
    item_o.gain    = s_axis_tdata[223:192];
    item_o.prey_vx = s_axis_tdata[255:224];
    item_o.prey_vy = s_axis_tdata[287:256];
  end

endmodule

// ----- rtl/sfi_fifo.sv -----
// Two-entry item queue between the decode front and the execution back end.
// Depends on sfi_pkg for the item type.
module sfi_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfi_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output sfi_pkg::item_t item_o
);

  sfi_pkg::item_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// ----- rtl/sfi_sqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
// Standalone; used by sfi_back for vector magnitudes.
module sfi_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o,
  output logic        done_o
);

  logic [63:0] val_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [35:0] rem_n, trial;

  assign rem_n  = {rem_q, val_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign root_o = root_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[61:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= 34'(rem_n - trial);
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_n[33:0];
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/sfi_div.sv -----
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// Standalone; shared by all divisions in sfi_back.
module sfi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic [63:0] quo_o,
  output logic        done_o
);

  logic [63:0] num_q;
  logic [31:0] den_q, rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] rem_n;

  assign rem_n  = {rem_q, num_q[63]};
  assign quo_o  = num_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (rem_n >= {1'b0, den_q}) begin
        rem_q <= 32'(rem_n - {1'b0, den_q});
        num_q <= {num_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_n[31:0];
        num_q <= {num_q[62:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/sfi_back.sv -----
// Execution sequencer: holds velocity and acceleration, runs each opcode on a shared
// multiplier, sfi_sqrt and sfi_div. Depends on sfi_pkg, sfi_sqrt, sfi_div.
module sfi_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sfi_pkg::cfg_t                    cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sfi_pkg::item_t                   in_item_i,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sfi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  sfi_pkg::state_e state_q, state_d, ret_q;
  sfi_pkg::item_t  item_q;
  sfi_pkg::q16_t   vel_x_q, vel_y_q, acc_x_q, acc_y_q;
  sfi_pkg::q16_t   dx_q, dy_q, ux_q, uy_q, fac_q, px_q, py_n;
  logic [31:0]     m_q;
  logic [63:0]     sum_q;
  logic signed [63:0] prod_q;
  logic [16:0]     slow_q;
  logic [30:0]     lead_q;
  logic [1:0]      sl_cnt_q;
  logic            neg_q, arr_q, velp_q, out_valid_q;
  logic [sfi_pkg::OUT_TDATA_W-1:0] out_data_q;

  sfi_pkg::q16_t   mul_a, mul_b;
  logic            div_start, sqrt_start, div_done, sqrt_done;
  logic [63:0]     div_num, div_quo, sqrt_rad, prod_abs;
  logic [31:0]     div_den, sqrt_root, limit, q_sig;
  logic            m_zero, slow_hit, evade_skip, lead_div, below_eps, clamp_need;
  logic            out_load;
  sfi_pkg::q16_t   q_res, qm;

  assign m_zero     = (m_q == 32'd0);
  assign slow_hit   = arr_q && (m_q <= {1'b0, cfg_i.arr_radius});
  assign evade_skip = (item_q.op == sfi_pkg::OP_EVADE) &&
                      (m_zero || (m_q > {1'b0, cfg_i.evade_dist}));
  assign lead_div   = !m_zero && (cfg_i.top_speed != 31'd0);
  assign limit      = velp_q ? {1'b0, cfg_i.max_speed} : {1'b0, cfg_i.max_force};
  assign below_eps  = velp_q && (m_q < {15'd0, cfg_i.rest_eps});
  assign clamp_need = !m_zero && (m_q > limit);
  assign prod_abs   = prod_q[63] ? (64'd0 - 64'(prod_q)) : 64'(prod_q);
  assign q_sig      = div_quo[31:0];
  assign q_res      = sfi_pkg::apply_sign(q_sig, neg_q);
  assign qm         = sfi_pkg::qmul_sat(prod_q);
  assign py_n       = sfi_pkg::sat_add(item_q.goal_y, qm);
  assign sqrt_rad   = sum_q + 64'(prod_q);
  assign out_load   = (state_q == sfi_pkg::S_DONE) && (!out_valid_q || m_axis_tready);

  assign in_ready_o    = (state_q == sfi_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  sfi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .root_o  (sqrt_root),
    .done_o  (sqrt_done)
  );

  sfi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfi_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_item_i.op) inside
            sfi_pkg::OP_PUSH: state_d = sfi_pkg::S_FRC_X;
            sfi_pkg::OP_SEEK, sfi_pkg::OP_FLEE, sfi_pkg::OP_ARRIVE, sfi_pkg::OP_PURSUE,
            sfi_pkg::OP_EVADE, sfi_pkg::OP_INTEG: state_d = sfi_pkg::S_MAG_X;
            default: state_d = sfi_pkg::S_DONE;
          endcase
        end
      end
      sfi_pkg::S_MAG_X:  state_d = sfi_pkg::S_MAG_Y;
      sfi_pkg::S_MAG_Y:  state_d = sfi_pkg::S_MAG_S;
      sfi_pkg::S_MAG_S:  state_d = sfi_pkg::S_MAG_W;
      sfi_pkg::S_MAG_W:  if (sqrt_done) state_d = ret_q;
      sfi_pkg::S_DIV_W:  if (div_done) state_d = ret_q;
      sfi_pkg::S_UNIT_X: state_d = m_zero ? sfi_pkg::S_DONE : sfi_pkg::S_DIV_W;
      sfi_pkg::S_UNIT_Y: state_d = sfi_pkg::S_DIV_W;
      sfi_pkg::S_UNIT_E: state_d = slow_hit ? sfi_pkg::S_DIV_W : sfi_pkg::S_FRC_X;
      sfi_pkg::S_SLOW:   state_d = sfi_pkg::S_SL_M;
      sfi_pkg::S_SL_M:   state_d = sfi_pkg::S_SL_W;
      sfi_pkg::S_SL_W:   state_d = (sl_cnt_q == 2'd3) ? sfi_pkg::S_FRC_X : sfi_pkg::S_SL_M;
      sfi_pkg::S_FRC_X:  state_d = sfi_pkg::S_FRC_Y;
      sfi_pkg::S_FRC_Y:  state_d = sfi_pkg::S_FRC_E;
      sfi_pkg::S_FRC_E:  state_d = sfi_pkg::S_DONE;
      sfi_pkg::S_PRED: begin
        if (evade_skip) state_d = sfi_pkg::S_DONE;
        else            state_d = lead_div ? sfi_pkg::S_DIV_W : sfi_pkg::S_FACT;
      end
      sfi_pkg::S_LEAD:   state_d = sfi_pkg::S_FACT;
      sfi_pkg::S_FACT:   state_d = sfi_pkg::S_FACT_W;
      sfi_pkg::S_FACT_W: state_d = sfi_pkg::S_PX;
      sfi_pkg::S_PX:     state_d = sfi_pkg::S_PY;
      sfi_pkg::S_PY:     state_d = sfi_pkg::S_PE;
      sfi_pkg::S_PE:     state_d = sfi_pkg::S_MAG_X;
      sfi_pkg::S_CL_A: begin
        if (below_eps)       state_d = sfi_pkg::S_DONE;
        else if (clamp_need) state_d = sfi_pkg::S_CL_B;
        else                 state_d = velp_q ? sfi_pkg::S_DONE : sfi_pkg::S_INT_V;
      end
      sfi_pkg::S_CL_B:   state_d = sfi_pkg::S_DIV_W;
      sfi_pkg::S_CL_C:   state_d = sfi_pkg::S_CL_D;
      sfi_pkg::S_CL_D:   state_d = sfi_pkg::S_DIV_W;
      sfi_pkg::S_CL_E:   state_d = velp_q ? sfi_pkg::S_DONE : sfi_pkg::S_INT_V;
      sfi_pkg::S_INT_V:  state_d = sfi_pkg::S_MAG_X;
      sfi_pkg::S_DONE:   if (out_load) state_d = sfi_pkg::S_IDLE;
      default:           state_d = sfi_pkg::S_IDLE;
    endcase
  end

  // Unit controls: multiplier operands and divider/root starts.
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = m_q;
    sqrt_start = 1'b0;
    unique case (state_q)
      sfi_pkg::S_MAG_X: begin mul_a = dx_q; mul_b = dx_q; end
      sfi_pkg::S_MAG_Y: begin mul_a = dy_q; mul_b = dy_q; end
      sfi_pkg::S_MAG_S: sqrt_start = 1'b1;
      sfi_pkg::S_UNIT_X: begin
        div_start = !m_zero;
        div_num   = {16'd0, sfi_pkg::abs_mag(dx_q), 16'd0};
      end
      sfi_pkg::S_UNIT_Y: begin
        div_start = 1'b1;
        div_num   = {16'd0, sfi_pkg::abs_mag(dy_q), 16'd0};
      end
      sfi_pkg::S_UNIT_E: begin
        div_start = slow_hit;
        div_num   = {16'd0, m_q, 16'd0};
        div_den   = {1'b0, cfg_i.arr_radius};
      end
      sfi_pkg::S_SL_M: begin
        mul_a = sl_cnt_q[1] ? uy_q : ux_q;
        mul_b = sfi_pkg::q16_t'({15'd0, slow_q});
      end
      sfi_pkg::S_FRC_X: begin mul_a = item_q.gain; mul_b = ux_q; end
      sfi_pkg::S_FRC_Y: begin mul_a = item_q.gain; mul_b = uy_q; end
      sfi_pkg::S_PRED: begin
        div_start = !evade_skip && lead_div;
        div_num   = {16'd0, m_q, 16'd0};
        div_den   = {1'b0, cfg_i.top_speed};
      end
      sfi_pkg::S_FACT: begin
        mul_a = sfi_pkg::q16_t'({1'b0, cfg_i.pred_damp});
        mul_b = sfi_pkg::q16_t'({1'b0, lead_q});
      end
      sfi_pkg::S_PX: begin mul_a = fac_q; mul_b = item_q.prey_vx; end
      sfi_pkg::S_PY: begin mul_a = fac_q; mul_b = item_q.prey_vy; end
      sfi_pkg::S_CL_A: begin mul_a = dx_q; mul_b = sfi_pkg::q16_t'(limit); end
      sfi_pkg::S_CL_B: begin div_start = 1'b1; div_num = prod_abs; end
      sfi_pkg::S_CL_C: begin mul_a = dy_q; mul_b = sfi_pkg::q16_t'(limit); end
      sfi_pkg::S_CL_D: begin div_start = 1'b1; div_num = prod_abs; end
      default: ;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfi_pkg::S_IDLE;
      ret_q       <= sfi_pkg::S_IDLE;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      sl_cnt_q    <= '0;
      arr_q       <= 1'b0;
      velp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        sfi_pkg::S_IDLE: begin
          if (in_valid_i) begin
            arr_q  <= (in_item_i.op == sfi_pkg::OP_ARRIVE) ||
                      (in_item_i.op == sfi_pkg::OP_PURSUE);
            velp_q <= 1'b0;
            unique case (in_item_i.op) inside
              sfi_pkg::OP_SEEK, sfi_pkg::OP_FLEE, sfi_pkg::OP_ARRIVE:
                ret_q <= sfi_pkg::S_UNIT_X;
              sfi_pkg::OP_PURSUE, sfi_pkg::OP_EVADE: ret_q <= sfi_pkg::S_PRED;
              sfi_pkg::OP_INTEG: ret_q <= sfi_pkg::S_CL_A;
              sfi_pkg::OP_HALT: begin
                vel_x_q <= '0;
                vel_y_q <= '0;
                acc_x_q <= '0;
                acc_y_q <= '0;
              end
              sfi_pkg::OP_CLEAR: begin
                acc_x_q <= '0;
                acc_y_q <= '0;
              end
              default: ;
            endcase
          end
        end
        sfi_pkg::S_UNIT_X: ret_q <= sfi_pkg::S_UNIT_Y;
        sfi_pkg::S_UNIT_Y: ret_q <= sfi_pkg::S_UNIT_E;
        sfi_pkg::S_UNIT_E: ret_q <= sfi_pkg::S_SLOW;
        sfi_pkg::S_SLOW:   sl_cnt_q <= '0;
        sfi_pkg::S_SL_W:   sl_cnt_q <= sl_cnt_q + 2'd1;
        sfi_pkg::S_FRC_Y:  acc_x_q <= sfi_pkg::sat_add(acc_x_q, qm);
        sfi_pkg::S_FRC_E:  acc_y_q <= sfi_pkg::sat_add(acc_y_q, qm);
        sfi_pkg::S_PRED:   ret_q <= sfi_pkg::S_LEAD;
        sfi_pkg::S_PE:     ret_q <= sfi_pkg::S_UNIT_X;
        sfi_pkg::S_CL_A: begin
          if (below_eps) begin
            vel_x_q <= '0;
            vel_y_q <= '0;
          end
        end
        sfi_pkg::S_CL_B:   ret_q <= sfi_pkg::S_CL_C;
        sfi_pkg::S_CL_C:   if (velp_q) vel_x_q <= q_res;
        sfi_pkg::S_CL_D:   ret_q <= sfi_pkg::S_CL_E;
        sfi_pkg::S_CL_E:   if (velp_q) vel_y_q <= q_res;
        sfi_pkg::S_INT_V: begin
          vel_x_q <= sfi_pkg::sat_add(vel_x_q, ux_q);
          vel_y_q <= sfi_pkg::sat_add(vel_y_q, uy_q);
          velp_q  <= 1'b1;
          ret_q   <= sfi_pkg::S_CL_A;
        end
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      sfi_pkg::S_IDLE: begin
        if (in_valid_i) begin
          item_q <= in_item_i;
          unique case (in_item_i.op) inside
            sfi_pkg::OP_PUSH: begin
              ux_q <= in_item_i.push_x;
              uy_q <= in_item_i.push_y;
            end
            sfi_pkg::OP_FLEE: begin
              dx_q <= sfi_pkg::sat_sub(in_item_i.own_x, in_item_i.goal_x);
              dy_q <= sfi_pkg::sat_sub(in_item_i.own_y, in_item_i.goal_y);
            end
            sfi_pkg::OP_INTEG: begin
              dx_q <= acc_x_q;
              dy_q <= acc_y_q;
            end
            default: begin
              dx_q <= sfi_pkg::sat_sub(in_item_i.goal_x, in_item_i.own_x);
              dy_q <= sfi_pkg::sat_sub(in_item_i.goal_y, in_item_i.own_y);
            end
          endcase
        end
      end
      sfi_pkg::S_MAG_Y:  sum_q <= 64'(prod_q);
      sfi_pkg::S_MAG_W:  if (sqrt_done) m_q <= sqrt_root;
      sfi_pkg::S_UNIT_X: neg_q <= dx_q[31];
      sfi_pkg::S_UNIT_Y: begin
        ux_q  <= q_res;
        neg_q <= dy_q[31];
      end
      sfi_pkg::S_UNIT_E: begin
        uy_q  <= q_res;
        neg_q <= 1'b0;
      end
      sfi_pkg::S_SLOW:   slow_q <= div_quo[16:0];
      sfi_pkg::S_SL_W: begin
        if (sl_cnt_q[1]) uy_q <= qm;
        else             ux_q <= qm;
      end
      sfi_pkg::S_PRED: begin
        neg_q  <= 1'b0;
        lead_q <= m_zero ? 31'd0 : 31'h7FFF_FFFF;
      end
      sfi_pkg::S_LEAD: begin
        lead_q <= (div_quo > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : div_quo[30:0];
      end
      sfi_pkg::S_FACT_W: fac_q <= qm;
      sfi_pkg::S_PY:     px_q <= sfi_pkg::sat_add(item_q.goal_x, qm);
      sfi_pkg::S_PE: begin
        if (item_q.op == sfi_pkg::OP_EVADE) begin
          dx_q <= sfi_pkg::sat_sub(item_q.own_x, px_q);
          dy_q <= sfi_pkg::sat_sub(item_q.own_y, py_n);
        end else begin
          dx_q <= sfi_pkg::sat_sub(px_q, item_q.own_x);
          dy_q <= sfi_pkg::sat_sub(py_n, item_q.own_y);
        end
      end
      sfi_pkg::S_CL_A: begin
        if (!clamp_need && !velp_q) begin
          ux_q <= dx_q;
          uy_q <= dy_q;
        end
      end
      sfi_pkg::S_CL_B:   neg_q <= prod_q[63];
      sfi_pkg::S_CL_C:   if (!velp_q) ux_q <= q_res;
      sfi_pkg::S_CL_D:   neg_q <= prod_q[63];
      sfi_pkg::S_CL_E:   if (!velp_q) uy_q <= q_res;
      sfi_pkg::S_INT_V: begin
        dx_q <= sfi_pkg::sat_add(vel_x_q, ux_q);
        dy_q <= sfi_pkg::sat_add(vel_y_q, uy_q);
      end
      sfi_pkg::S_DONE: begin
        if (out_load) begin
          out_data_q <= {7'd0, (vel_x_q != 32'sd0) || (vel_y_q != 32'sd0),
                         acc_y_q, acc_x_q, vel_y_q, vel_x_q};
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/steering_force_integrator.sv -----
// Top level of the steering force integrator: configuration registers and the
// front / queue / back split. Depends on sfi_pkg, sfi_front, sfi_fifo, sfi_back.
//
//   Port group   Direction  Handshake              Contents
//   s_axis_*     in         tvalid/tready          one steering command item
//   m_axis_*     out        tvalid/tready          velocity, acceleration, moving flag
//   cfg_*        in         cfg_valid_i/cfg_ready_o register index and write data
//
// Items run one at a time in the back end. Every vector magnitude holds the square-root
// unit and every division the restoring divider until its result is done; seek and flee
// use one magnitude and two divisions, and pursue, evade and integrate up to two
// magnitudes and more divisions.
// Reset clears velocity, acceleration and the queue and loads the register defaults.
// The front keeps taking items into a two-entry queue while the back end works, and a
// finished result waits in the output register without stopping the next item's start.
module steering_force_integrator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // own_x, own_y, goal_x, goal_y, push_x, push_y, gain, prey_vx, prey_vy (32 bits each)
  input  logic [sfi_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // opcode
  input  logic [sfi_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_vel_x, out_vel_y, out_acc_x, out_acc_y (32 bits each), moving, 7 zero bits
  output logic [sfi_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sfi_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sfi_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  sfi_pkg::cfg_t  cfg_q;
  sfi_pkg::item_t front_item, queue_item;
  logic           push, full, q_valid, q_pop;

  // Registers are always writable; the user must write them only while the block is idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_force  <= 31'd65536;
      cfg_q.max_speed  <= 31'd262144;
      cfg_q.rest_eps   <= 17'd66;
      cfg_q.arr_radius <= 31'd655360;
      cfg_q.evade_dist <= 31'd655360;
      cfg_q.pred_damp  <= 31'd65536;
      cfg_q.top_speed  <= 31'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sfi_pkg::CFG_MAX_FORCE:  cfg_q.max_force  <= cfg_data_i[30:0];
        sfi_pkg::CFG_MAX_SPEED:  cfg_q.max_speed  <= cfg_data_i[30:0];
        sfi_pkg::CFG_REST_EPS:   cfg_q.rest_eps   <= cfg_data_i[16:0];
        sfi_pkg::CFG_ARR_RADIUS: cfg_q.arr_radius <= cfg_data_i[30:0];
        sfi_pkg::CFG_EVADE_DIST: cfg_q.evade_dist <= cfg_data_i[30:0];
        sfi_pkg::CFG_PRED_DAMP:  cfg_q.pred_damp  <= cfg_data_i[30:0];
        sfi_pkg::CFG_TOP_SPEED:  cfg_q.top_speed  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  sfi_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .item_o        (front_item)
  );

  sfi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (queue_item)
  );

  sfi_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (q_valid),
    .in_ready_o    (q_pop),
    .in_item_i     (queue_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
